/* hw/rtl/rvdec_pkg.sv */
// rvdec_pkg: word types, opcode constants and operation codes for the
// rv32i instruction decoder. Depends on nothing.

package rvdec_pkg;

   typedef struct packed {
      logic [31:0] instruction;
      logic [31:0] fetch_pc;
      logic        predict_taken;
   } req_type;

   typedef struct packed {
      logic [5:0]         operation;
      logic [5:0]         src1_reg;
      logic [5:0]         src2_reg;
      logic [5:0]         dest_reg;
      logic signed [31:0] immediate;
      logic [31:0]        next_pc;
      logic               predicted_jump;
   } rsp_type;

   localparam logic [6:0] OPC_RTYPE  = 7'b0110011;
   localparam logic [6:0] OPC_IARITH = 7'b0010011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;

   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_SB = 3'd0;
   localparam logic [2:0] F3_SH = 3'd1;
   localparam logic [2:0] F3_SW = 3'd2;

   localparam logic [5:0] NO_REG = 6'd32;

   localparam logic [5:0] OP_UNKNOWN = 6'd0;
   localparam logic [5:0] OP_ADD     = 6'd1;
   localparam logic [5:0] OP_SUB     = 6'd2;
   localparam logic [5:0] OP_SLL     = 6'd3;
   localparam logic [5:0] OP_SLT     = 6'd4;
   localparam logic [5:0] OP_SLTU    = 6'd5;
   localparam logic [5:0] OP_XOR     = 6'd6;
   localparam logic [5:0] OP_SRL     = 6'd7;
   localparam logic [5:0] OP_SRA     = 6'd8;
   localparam logic [5:0] OP_OR      = 6'd9;
   localparam logic [5:0] OP_AND     = 6'd10;
   localparam logic [5:0] OP_ADDI    = 6'd11;
   localparam logic [5:0] OP_SLTI    = 6'd12;
   localparam logic [5:0] OP_SLTIU   = 6'd13;
   localparam logic [5:0] OP_XORI    = 6'd14;
   localparam logic [5:0] OP_ORI     = 6'd15;
   localparam logic [5:0] OP_ANDI    = 6'd16;
   localparam logic [5:0] OP_SLLI    = 6'd17;
   localparam logic [5:0] OP_SRLI    = 6'd18;
   localparam logic [5:0] OP_SRAI    = 6'd19;
   localparam logic [5:0] OP_LB      = 6'd20;
   localparam logic [5:0] OP_LH      = 6'd21;
   localparam logic [5:0] OP_LW      = 6'd22;
   localparam logic [5:0] OP_LBU     = 6'd23;
   localparam logic [5:0] OP_LHU     = 6'd24;
   localparam logic [5:0] OP_BEQ     = 6'd25;
   localparam logic [5:0] OP_BNE     = 6'd26;
   localparam logic [5:0] OP_BLT     = 6'd27;
   localparam logic [5:0] OP_BGE     = 6'd28;
   localparam logic [5:0] OP_BLTU    = 6'd29;
   localparam logic [5:0] OP_BGEU    = 6'd30;
   localparam logic [5:0] OP_SB      = 6'd31;
   localparam logic [5:0] OP_SH      = 6'd32;
   localparam logic [5:0] OP_SW      = 6'd33;
   localparam logic [5:0] OP_LUI     = 6'd34;
   localparam logic [5:0] OP_AUIPC   = 6'd35;
   localparam logic [5:0] OP_JAL     = 6'd36;
   localparam logic [5:0] OP_JALR    = 6'd37;

endpackage

/* hw/rtl/rv32i_instruction_decoder.sv */
// rv32i_instruction_decoder: two-register decode pipeline for rv32i words.
// Depends on rvdec_pkg for the word types, opcodes and operation codes.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data) carries one instruction word
//    with its fetch pc and the predictor's taken bit.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) returns the decoded word:
//    operation code, register numbers (32 for an unused slot), immediate,
//    next pc and predicted-jump flag.
//  - the word passes an input register, the decode logic and the next-pc
//    adder, then the result register, which drives rsp_valid and rsp_data.
//  - throughput is one word per cycle while rsp_ready holds; both registers
//    advance together whenever the result register is empty or being taken.
//  - when rsp_ready is low the result holds and one more word is still
//    accepted into the input register; req_ready then drops until the
//    receiver takes the result.
//  - reset empties both registers; no words are in flight afterwards.

module rv32i_instruction_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rvdec_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rvdec_pkg::rsp_type rsp_data
);

   import rvdec_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_word_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_word_ff;
   rsp_type dec_word;
   logic    out_load;

   logic [31:0]        inst;
   logic [6:0]         opc;
   logic [2:0]         f3;
   logic [6:0]         f7;
   logic [5:0]         r1;
   logic [5:0]         r2;
   logic [5:0]         rdv;
   logic signed [31:0] iimm;
   logic signed [31:0] bimm;
   logic signed [31:0] simm;
   logic signed [31:0] jimm;
   logic signed [31:0] uimm;
   logic signed [31:0] shamt;
   logic               take_target;

   assign out_load  = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_load;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   assign inst  = in_word_ff.instruction;
   assign opc   = inst[6:0];
   assign f3    = inst[14:12];
   assign f7    = inst[31:25];
   assign r1    = {1'b0, inst[19:15]};
   assign r2    = {1'b0, inst[24:20]};
   assign rdv   = {1'b0, inst[11:7]};
   assign iimm  = {{20{inst[31]}}, inst[31:20]};
   assign simm  = {{20{inst[31]}}, inst[31:25], inst[11:7]};
   assign bimm  = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
   assign jimm  = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
   assign uimm  = {inst[31:12], 12'b0};
   assign shamt = {27'b0, inst[24:20]};

   always_comb begin
      dec_word                = '0;
      dec_word.operation      = OP_UNKNOWN;
      dec_word.src1_reg       = NO_REG;
      dec_word.src2_reg       = NO_REG;
      dec_word.dest_reg       = NO_REG;
      dec_word.immediate      = '0;
      dec_word.predicted_jump = 1'b0;
      take_target             = 1'b0;
      case (opc)
         OPC_RTYPE: begin
            dec_word.src1_reg = r1;
            dec_word.src2_reg = r2;
            dec_word.dest_reg = rdv;
            case (f3)
               F3_ADD: begin
                  if (f7 == F7_BASE) dec_word.operation = OP_ADD;
                  else if (f7 == F7_ALT) dec_word.operation = OP_SUB;
               end
               F3_SLL:  dec_word.operation = OP_SLL;
               F3_SLT:  dec_word.operation = OP_SLT;
               F3_SLTU: dec_word.operation = OP_SLTU;
               F3_XOR:  dec_word.operation = OP_XOR;
               F3_SR: begin
                  if (f7 == F7_BASE) dec_word.operation = OP_SRL;
                  else if (f7 == F7_ALT) dec_word.operation = OP_SRA;
               end
               F3_OR:   dec_word.operation = OP_OR;
               default: dec_word.operation = OP_AND;
            endcase
         end
         OPC_IARITH: begin
            dec_word.src1_reg  = r1;
            dec_word.dest_reg  = rdv;
            dec_word.immediate = iimm;
            case (f3)
               F3_ADD:  dec_word.operation = OP_ADDI;
               F3_SLL: begin
                  dec_word.operation = OP_SLLI;
                  dec_word.immediate = shamt;
               end
               F3_SLT:  dec_word.operation = OP_SLTI;
               F3_SLTU: dec_word.operation = OP_SLTIU;
               F3_XOR:  dec_word.operation = OP_XORI;
               F3_SR: begin
                  dec_word.immediate = shamt;
                  if (f7 == F7_BASE) dec_word.operation = OP_SRLI;
                  else if (f7 == F7_ALT) dec_word.operation = OP_SRAI;
               end
               F3_OR:   dec_word.operation = OP_ORI;
               default: dec_word.operation = OP_ANDI;
            endcase
         end
         OPC_LOAD: begin
            dec_word.src1_reg  = r1;
            dec_word.dest_reg  = rdv;
            dec_word.immediate = iimm;
            case (f3)
               F3_LB:   dec_word.operation = OP_LB;
               F3_LH:   dec_word.operation = OP_LH;
               F3_LW:   dec_word.operation = OP_LW;
               F3_LBU:  dec_word.operation = OP_LBU;
               F3_LHU:  dec_word.operation = OP_LHU;
               default: dec_word.operation = OP_UNKNOWN;
            endcase
         end
         OPC_BRANCH: begin
            dec_word.src1_reg       = r1;
            dec_word.src2_reg       = r2;
            dec_word.immediate      = bimm;
            dec_word.predicted_jump = in_word_ff.predict_taken;
            take_target             = in_word_ff.predict_taken;
            case (f3)
               F3_BEQ:  dec_word.operation = OP_BEQ;
               F3_BNE:  dec_word.operation = OP_BNE;
               F3_BLT:  dec_word.operation = OP_BLT;
               F3_BGE:  dec_word.operation = OP_BGE;
               F3_BLTU: dec_word.operation = OP_BLTU;
               F3_BGEU: dec_word.operation = OP_BGEU;
               default: dec_word.operation = OP_UNKNOWN;
            endcase
         end
         OPC_STORE: begin
            dec_word.src1_reg  = r1;
            dec_word.src2_reg  = r2;
            dec_word.dest_reg  = rdv;
            dec_word.immediate = simm;
            case (f3)
               F3_SB:   dec_word.operation = OP_SB;
               F3_SH:   dec_word.operation = OP_SH;
               F3_SW:   dec_word.operation = OP_SW;
               default: dec_word.operation = OP_UNKNOWN;
            endcase
         end
         OPC_LUI: begin
            dec_word.dest_reg  = rdv;
            dec_word.immediate = uimm;
            dec_word.operation = OP_LUI;
         end
         OPC_AUIPC: begin
            dec_word.dest_reg  = rdv;
            dec_word.immediate = uimm;
            dec_word.operation = OP_AUIPC;
         end
         OPC_JAL: begin
            dec_word.dest_reg  = rdv;
            dec_word.immediate = jimm;
            dec_word.operation = OP_JAL;
            take_target        = 1'b1;
         end
         OPC_JALR: begin
            dec_word.src1_reg  = r1;
            dec_word.dest_reg  = rdv;
            dec_word.immediate = iimm;
            dec_word.operation = OP_JALR;
         end
         default: begin
            dec_word.operation = OP_UNKNOWN;
         end
      endcase
      if (take_target) begin
         dec_word.next_pc = in_word_ff.fetch_pc + unsigned'(dec_word.immediate);
      end else begin
         dec_word.next_pc = in_word_ff.fetch_pc + 32'd4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_word_ff <= req_data;
      end
      if (out_load) begin
         out_word_ff <= dec_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule

/* tb/rv32i_instruction_decoder_test.sv */
`timescale 1ns / 1ps
// rv32i_instruction_decoder_test: self-checking bench for the rv32i decoder.
// Depends on rvdec_pkg and rv32i_instruction_decoder; decodes each word on
// its own side and compares every field of every result in order.

module rv32i_instruction_decoder_test;
   import rvdec_pkg::*;

   localparam int HANG_LIMIT = 1000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type pending_decodes[$];
   int      mismatch_count = 0;
   int      stuck_cycles = 0;
   int      send_calm = 0;
   int      recv_calm = 0;

   rv32i_instruction_decoder DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type decode_instruction(req_type w);
      rsp_type     r;
      logic [31:0] i;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] iimm;
      i = w.instruction;
      f3 = i[14:12];
      f7 = i[31:25];
      iimm = {{20{i[31]}}, i[31:20]};
      r.operation = OP_UNKNOWN;
      r.src1_reg = NO_REG;
      r.src2_reg = NO_REG;
      r.dest_reg = NO_REG;
      r.immediate = '0;
      r.next_pc = w.fetch_pc + 32'd4;
      r.predicted_jump = 1'b0;
      case (i[6:0])
         OPC_RTYPE: begin
            r.src1_reg = {1'b0, i[19:15]};
            r.src2_reg = {1'b0, i[24:20]};
            r.dest_reg = {1'b0, i[11:7]};
            case (f3)
               F3_ADD: r.operation = (f7 == F7_BASE) ? OP_ADD :
                                     (f7 == F7_ALT) ? OP_SUB : OP_UNKNOWN;
               F3_SLL: r.operation = OP_SLL;
               F3_SLT: r.operation = OP_SLT;
               F3_SLTU: r.operation = OP_SLTU;
               F3_XOR: r.operation = OP_XOR;
               F3_SR: r.operation = (f7 == F7_BASE) ? OP_SRL :
                                    (f7 == F7_ALT) ? OP_SRA : OP_UNKNOWN;
               F3_OR: r.operation = OP_OR;
               default: r.operation = OP_AND;
            endcase
         end
         OPC_IARITH: begin
            r.src1_reg = {1'b0, i[19:15]};
            r.dest_reg = {1'b0, i[11:7]};
            if (f3 == F3_SLL || f3 == F3_SR) begin
               r.immediate = {27'b0, i[24:20]};
            end else begin
               r.immediate = iimm;
            end
            case (f3)
               F3_ADD: r.operation = OP_ADDI;
               F3_SLL: r.operation = OP_SLLI;
               F3_SLT: r.operation = OP_SLTI;
               F3_SLTU: r.operation = OP_SLTIU;
               F3_XOR: r.operation = OP_XORI;
               F3_SR: r.operation = (f7 == F7_BASE) ? OP_SRLI :
                                    (f7 == F7_ALT) ? OP_SRAI : OP_UNKNOWN;
               F3_OR: r.operation = OP_ORI;
               default: r.operation = OP_ANDI;
            endcase
         end
         OPC_LOAD: begin
            r.src1_reg = {1'b0, i[19:15]};
            r.dest_reg = {1'b0, i[11:7]};
            r.immediate = iimm;
            case (f3)
               F3_LB: r.operation = OP_LB;
               F3_LH: r.operation = OP_LH;
               F3_LW: r.operation = OP_LW;
               F3_LBU: r.operation = OP_LBU;
               F3_LHU: r.operation = OP_LHU;
               default: r.operation = OP_UNKNOWN;
            endcase
         end
         OPC_BRANCH: begin
            r.src1_reg = {1'b0, i[19:15]};
            r.src2_reg = {1'b0, i[24:20]};
            r.immediate = {{20{i[31]}}, i[7], i[30:25], i[11:8], 1'b0};
            r.predicted_jump = w.predict_taken;
            if (w.predict_taken) begin
               r.next_pc = w.fetch_pc + $unsigned(r.immediate);
            end
            case (f3)
               F3_BEQ: r.operation = OP_BEQ;
               F3_BNE: r.operation = OP_BNE;
               F3_BLT: r.operation = OP_BLT;
               F3_BGE: r.operation = OP_BGE;
               F3_BLTU: r.operation = OP_BLTU;
               F3_BGEU: r.operation = OP_BGEU;
               default: r.operation = OP_UNKNOWN;
            endcase
         end
         OPC_STORE: begin
            r.src1_reg = {1'b0, i[19:15]};
            r.src2_reg = {1'b0, i[24:20]};
            r.dest_reg = {1'b0, i[11:7]};
            r.immediate = {{20{i[31]}}, i[31:25], i[11:7]};
            case (f3)
               F3_SB: r.operation = OP_SB;
               F3_SH: r.operation = OP_SH;
               F3_SW: r.operation = OP_SW;
               default: r.operation = OP_UNKNOWN;
            endcase
         end
         OPC_LUI: begin
            r.dest_reg = {1'b0, i[11:7]};
            r.immediate = {i[31:12], 12'b0};
            r.operation = OP_LUI;
         end
         OPC_AUIPC: begin
            r.dest_reg = {1'b0, i[11:7]};
            r.immediate = {i[31:12], 12'b0};
            r.operation = OP_AUIPC;
         end
         OPC_JAL: begin
            r.dest_reg = {1'b0, i[11:7]};
            r.immediate = {{11{i[31]}}, i[31], i[19:12], i[20], i[30:21], 1'b0};
            r.next_pc = w.fetch_pc + $unsigned(r.immediate);
            r.operation = OP_JAL;
         end
         OPC_JALR: begin
            r.src1_reg = {1'b0, i[19:15]};
            r.dest_reg = {1'b0, i[11:7]};
            r.immediate = iimm;
            r.operation = OP_JALR;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // mostly random waits, now and then a run of back-to-back words
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(15, 60);
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [31:0] build_word(logic [6:0] opc, logic [2:0] f3,
                                              logic [6:0] f7);
      logic [31:0] word;
      word = $urandom();
      word[6:0] = opc;
      word[14:12] = f3;
      word[31:25] = f7;
      return word;
   endfunction

   function automatic logic [6:0] known_opcode(int sel);
      case (sel)
         0: return OPC_RTYPE;
         1: return OPC_IARITH;
         2: return OPC_LOAD;
         3: return OPC_BRANCH;
         4: return OPC_STORE;
         5: return OPC_LUI;
         6: return OPC_AUIPC;
         7: return OPC_JAL;
         default: return OPC_JALR;
      endcase
   endfunction

   function automatic logic [31:0] random_instruction();
      logic [31:0] word;
      int          sel;
      word = $urandom();
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
         word[6:0] = known_opcode($urandom_range(0, 8));
         if ($urandom_range(0, 3) != 0) begin
            word[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
         end
      end else if (sel < 95) begin
         word[1:0] = 2'b11;
      end
      return word;
   endfunction

   task automatic send_word(input logic [31:0] instruction, input logic [31:0] pc,
                            input logic taken);
      int gap;
      req_type w;
      gap = draw_wait(send_calm);
      w.instruction = instruction;
      w.fetch_pc = pc;
      w.predict_taken = taken;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_decodes.push_back(decode_instruction(w));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic compare_decode(input rsp_type got);
      rsp_type want;
      if (pending_decodes.size() == 0) begin
         $error("result word with nothing outstanding: %h", got);
         mismatch_count++;
      end else begin
         want = pending_decodes.pop_front();
         compare_field("operation", 32'(want.operation), 32'(got.operation));
         compare_field("src1_reg", 32'(want.src1_reg), 32'(got.src1_reg));
         compare_field("src2_reg", 32'(want.src2_reg), 32'(got.src2_reg));
         compare_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
         compare_field("immediate", want.immediate, got.immediate);
         compare_field("next_pc", want.next_pc, got.next_pc);
         compare_field("predicted_jump", 32'(want.predicted_jump),
                       32'(got.predicted_jump));
      end
   endtask

   task automatic test_every_operation();
      int f3;
      for (f3 = 0; f3 < 8; f3++) begin
         send_word(build_word(OPC_RTYPE, 3'(f3), F7_BASE), $urandom(),
                   1'($urandom_range(0, 1)));
         send_word(build_word(OPC_IARITH, 3'(f3), F7_BASE), $urandom(),
                   1'($urandom_range(0, 1)));
         send_word(build_word(OPC_LOAD, 3'(f3), 7'($urandom())), $urandom(),
                   1'($urandom_range(0, 1)));
         send_word(build_word(OPC_BRANCH, 3'(f3), 7'($urandom())), $urandom(),
                   1'($urandom_range(0, 1)));
         send_word(build_word(OPC_STORE, 3'(f3), 7'($urandom())), $urandom(),
                   1'($urandom_range(0, 1)));
      end
      send_word(build_word(OPC_RTYPE, F3_ADD, F7_ALT), $urandom(), 1'b0);
      send_word(build_word(OPC_RTYPE, F3_SR, F7_ALT), $urandom(), 1'b1);
      send_word(build_word(OPC_IARITH, F3_SR, F7_ALT), $urandom(), 1'b0);
      send_word(build_word(OPC_LUI, 3'($urandom()), 7'($urandom())), $urandom(), 1'b1);
      send_word(build_word(OPC_AUIPC, 3'($urandom()), 7'($urandom())), $urandom(), 1'b0);
      send_word(build_word(OPC_JAL, 3'($urandom()), 7'($urandom())), $urandom(), 1'b1);
      send_word(build_word(OPC_JALR, 3'($urandom()), 7'($urandom())), $urandom(), 1'b1);
      wait_for_drain();
   endtask

   task automatic test_special_cases();
      // unknown opcodes at both extremes of the word and the pc
      send_word(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      // funct7 that matches neither choice
      send_word(build_word(OPC_RTYPE, F3_ADD, 7'h01), 32'h0000_1000, 1'b0);
      send_word(build_word(OPC_RTYPE, F3_SR, 7'h7F), 32'h0000_1004, 1'b0);
      send_word(build_word(OPC_IARITH, F3_SR, 7'h7F), 32'h0000_1008, 1'b1);
      // funct7 ignored where it selects nothing
      send_word(build_word(OPC_IARITH, F3_SLL, 7'h7F), 32'h0000_100C, 1'b0);
      send_word(build_word(OPC_RTYPE, F3_XOR, 7'h55), 32'h0000_1010, 1'b0);
      // taken branches at the offset extremes, with pc wrap
      send_word({1'b1, 6'h00, 5'd31, 5'd31, F3_BNE, 4'h0, 1'b0, OPC_BRANCH},
                32'h0000_0000, 1'b1);
      send_word({1'b0, 6'h3F, 5'd0, 5'd0, F3_BGEU, 4'hF, 1'b1, OPC_BRANCH},
                32'hFFFF_FFFC, 1'b1);
      // jumps at the offset extremes, predictor bit must not leak
      send_word({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL}, 32'h0000_0000, 1'b1);
      send_word({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, OPC_JAL}, 32'hFFFF_FFFC, 1'b1);
      send_word({12'h800, 5'd31, 3'd0, 5'd0, OPC_JALR}, 32'hFFFF_FFFC, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_random_words(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         if (n == count / 2) begin
            wait_for_drain();
         end
         send_word(random_instruction(), $urandom(), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_every_operation();
      test_special_cases();
      test_random_words(1750);
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_decodes.size() == 0) begin
         $display("rv32i_instruction_decoder test passed");
      end else begin
         $display("rv32i_instruction_decoder test failed");
      end
      $finish;
   end

   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(recv_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         compare_decode(rsp_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= HANG_LIMIT) begin
         $display("rv32i_instruction_decoder test failed");
         $finish;
      end
   end

endmodule
